FILE: hw/rtl/sprite_quad_vertex_expander_defines.svh
// ----------------------------------------------------------------------------
// Sprite quad vertex expander: assertion macros
// Shared concurrent assertion forms used by the expander modules.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_VERTEX_EXPANDER_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_EXPANDER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SVQE_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SVQE_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/svqe_pkg.sv
// ----------------------------------------------------------------------------
// svqe_pkg
// Widths, register indexes, reset values and shared types of the sprite quad
// vertex expander.
// ----------------------------------------------------------------------------
`default_nettype none

package svqe_pkg;

  localparam int POS_W   = 24;  // signed Q16.8 positions
  localparam int TEX_W   = 24;  // unsigned Q8.16 texture coordinates
  localparam int SRC_W   = 16;  // texel edges
  localparam int EDGE_W  = SRC_W + 1;
  localparam int COEF_W  = 16;  // signed Q4.12 coefficients
  localparam int INV_W   = 24;  // unsigned Q1.23 reciprocals
  localparam int ROW_W   = 56;
  localparam int TEXS_W  = 48;
  localparam int COLOR_W = 32;
  localparam int SLOT_W  = 3;
  localparam int CFG_W   = 56;
  localparam int IDX_W   = 3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd5;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_ROW_X     = 3'd0,
    CFG_ROW_Y     = 3'd1,
    CFG_ROW_Z     = 3'd2,
    CFG_TEX_INV   = 3'd3,
    CFG_COLOR_A   = 3'd4,
    CFG_COLOR_B   = 3'd5,
    CFG_COLOR_C   = 3'd6,
    CFG_COLOR_D   = 3'd7
  } cfg_reg_t;

  localparam logic [ROW_W-1:0]   ROW_X_RST = 56'h00_0000_0000_1000;
  localparam logic [ROW_W-1:0]   ROW_Y_RST = 56'h00_0000_1000_0000;
  localparam logic [ROW_W-1:0]   ROW_Z_RST = 56'h0;
  localparam logic [TEXS_W-1:0]  TEX_INV_RST = 48'h8000_0080_0000;
  localparam logic [COLOR_W-1:0] COLOR_RST = 32'hFFFF_FFFF;

  // Quad corners: A origin, B (0,h), C (w,h), D (w,0)
  typedef enum logic [1:0] {
    CORNER_A = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2,
    CORNER_D = 2'd3
  } corner_t;

  typedef struct packed {
    logic signed [POS_W-1:0] dst_left;
    logic signed [POS_W-1:0] dst_top;
    logic signed [POS_W-1:0] dst_width;
    logic signed [POS_W-1:0] dst_height;
    logic [SRC_W-1:0]        src_left;
    logic [SRC_W-1:0]        src_top;
    logic [SRC_W-1:0]        src_width;
    logic [SRC_W-1:0]        src_height;
  } quad_t;

  // Sequencer to datapath: one vertex slot of the held quad
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    quad_t             quad;
  } seq_item_t;

  // Triangle order 0,1,2,0,2,3
  function automatic corner_t corner_of(input logic [SLOT_W-1:0] slot);
    corner_t c;
    case (slot)
      3'd0:    c = CORNER_A;
      3'd1:    c = CORNER_B;
      3'd2:    c = CORNER_C;
      3'd3:    c = CORNER_A;
      3'd4:    c = CORNER_C;
      3'd5:    c = CORNER_D;
      default: c = CORNER_A;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/svqe_quad_if.sv
// ----------------------------------------------------------------------------
// svqe_quad_if
// Quad input channel: valid/ready handshake with the sprite quad payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface svqe_quad_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [svqe_pkg::POS_W-1:0]     dst_left;
  logic signed [svqe_pkg::POS_W-1:0]     dst_top;
  logic signed [svqe_pkg::POS_W-1:0]     dst_width;
  logic signed [svqe_pkg::POS_W-1:0]     dst_height;
  logic [svqe_pkg::SRC_W-1:0]            src_left;
  logic [svqe_pkg::SRC_W-1:0]            src_top;
  logic [svqe_pkg::SRC_W-1:0]            src_width;
  logic [svqe_pkg::SRC_W-1:0]            src_height;

  modport source (
    output valid, dst_left, dst_top, dst_width, dst_height,
           src_left, src_top, src_width, src_height,
    input  ready
  );

  modport sink (
    input  valid, dst_left, dst_top, dst_width, dst_height,
           src_left, src_top, src_width, src_height,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/svqe_vertex_if.sv
// ----------------------------------------------------------------------------
// svqe_vertex_if
// Vertex output channel: valid/ready handshake with one triangle vertex.
// ----------------------------------------------------------------------------
`default_nettype none

interface svqe_vertex_if;
  logic                                valid;
  logic                                ready;
  logic signed [svqe_pkg::POS_W-1:0]   pos_x;
  logic signed [svqe_pkg::POS_W-1:0]   pos_y;
  logic signed [svqe_pkg::POS_W-1:0]   pos_z;
  logic [svqe_pkg::TEX_W-1:0]          tex_u;
  logic [svqe_pkg::TEX_W-1:0]          tex_v;
  logic [svqe_pkg::COLOR_W-1:0]        vertex_color;
  logic [svqe_pkg::SLOT_W-1:0]         vertex_slot;
  logic                                last_vertex;

  modport source (
    output valid, pos_x, pos_y, pos_z, tex_u, tex_v,
           vertex_color, vertex_slot, last_vertex,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, tex_u, tex_v,
           vertex_color, vertex_slot, last_vertex,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/sprite_quad_vertex_expander.sv
// ----------------------------------------------------------------------------
// sprite_quad_vertex_expander
// Expands each sprite quad into six triangle vertices (corners 0,1,2,0,2,3)
// with transformed positions, texture coordinates and corner colours.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake              carries
//   quad      in    quad.valid/ready       destination and source rectangles
//   vertex    out   vertex.valid/ready     one vertex per transaction
//   cfg       in    cfg_we (no wait)       register index and write data
//
// One vertex leaves per cycle while the output is not stalled; the slot
// sequencer holding the quad sets that rate.
// After the quad is taken, its first vertex passes through the sequencer,
// select, multiply, sum and saturate/output registers in that order.
// rst (synchronous) clears the valid bits and the configuration to its
// reset values; payload registers are not reset.
// A stall at the output holds every stage; a new quad is still taken while
// the sequencer is empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sprite_quad_vertex_expander_defines.svh"

module sprite_quad_vertex_expander (
  input  wire logic                          clk,
  input  wire logic                          rst,
  svqe_quad_if.sink                          quad,
  svqe_vertex_if.source                      vertex,
  input  wire logic                          cfg_we,
  input  wire logic [svqe_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [svqe_pkg::CFG_W-1:0]    cfg_data
);

  // Configuration registers
  logic [svqe_pkg::ROW_W-1:0]   row_x;
  logic [svqe_pkg::ROW_W-1:0]   row_y;
  logic [svqe_pkg::ROW_W-1:0]   row_z;
  logic [svqe_pkg::TEXS_W-1:0]  tex_inv_scale;
  logic [svqe_pkg::COLOR_W-1:0] color_a;
  logic [svqe_pkg::COLOR_W-1:0] color_b;
  logic [svqe_pkg::COLOR_W-1:0] color_c;
  logic [svqe_pkg::COLOR_W-1:0] color_d;

  // Pipeline control
  logic adv;
  logic v1, v2, v3, v4;
  svqe_pkg::seq_item_t seq_item;
  svqe_pkg::corner_t   corner;

  // Stage 1 registers
  logic signed [svqe_pkg::POS_W-1:0] px1;
  logic signed [svqe_pkg::POS_W-1:0] py1;
  logic signed [svqe_pkg::POS_W-1:0] ox1;
  logic signed [svqe_pkg::POS_W-1:0] oy1;
  logic [svqe_pkg::EDGE_W-1:0]       edge_u1;
  logic [svqe_pkg::EDGE_W-1:0]       edge_v1;

  // Sideband carried alongside the lanes
  logic [svqe_pkg::COLOR_W-1:0] color1, color2, color3, color4;
  logic [svqe_pkg::SLOT_W-1:0]  slot1, slot2, slot3, slot4;
  logic                         last1, last2, last3, last4;

  logic signed [svqe_pkg::POS_W-1:0] res_x;
  logic signed [svqe_pkg::POS_W-1:0] res_y;
  logic signed [svqe_pkg::POS_W-1:0] res_z;
  logic [svqe_pkg::TEX_W-1:0]        res_u;
  logic [svqe_pkg::TEX_W-1:0]        res_v;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x         <= svqe_pkg::ROW_X_RST;
      row_y         <= svqe_pkg::ROW_Y_RST;
      row_z         <= svqe_pkg::ROW_Z_RST;
      tex_inv_scale <= svqe_pkg::TEX_INV_RST;
      color_a       <= svqe_pkg::COLOR_RST;
      color_b       <= svqe_pkg::COLOR_RST;
      color_c       <= svqe_pkg::COLOR_RST;
      color_d       <= svqe_pkg::COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        svqe_pkg::CFG_ROW_X:   row_x         <= cfg_data;
        svqe_pkg::CFG_ROW_Y:   row_y         <= cfg_data;
        svqe_pkg::CFG_ROW_Z:   row_z         <= cfg_data;
        svqe_pkg::CFG_TEX_INV: tex_inv_scale <= cfg_data[47:0];
        svqe_pkg::CFG_COLOR_A: color_a       <= cfg_data[31:0];
        svqe_pkg::CFG_COLOR_B: color_b       <= cfg_data[31:0];
        svqe_pkg::CFG_COLOR_C: color_c       <= cfg_data[31:0];
        svqe_pkg::CFG_COLOR_D: color_d       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless a finished vertex is waiting
  assign adv = !v4 || vertex.ready;

  svqe_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .quad (quad),
    .adv  (adv),
    .item (seq_item)
  );

  assign corner = svqe_pkg::corner_of(seq_item.slot);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= seq_item.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage 1: pick corner offsets, texel edges and colour
  always_ff @(posedge clk) begin
    if (adv) begin
      px1 <= (corner == svqe_pkg::CORNER_C || corner == svqe_pkg::CORNER_D)
             ? seq_item.quad.dst_width : '0;
      py1 <= (corner == svqe_pkg::CORNER_B || corner == svqe_pkg::CORNER_C)
             ? seq_item.quad.dst_height : '0;
      ox1 <= seq_item.quad.dst_left;
      oy1 <= seq_item.quad.dst_top;
      if (corner == svqe_pkg::CORNER_C || corner == svqe_pkg::CORNER_D) begin
        edge_u1 <= 17'(seq_item.quad.src_left) + 17'(seq_item.quad.src_width);
      end else begin
        edge_u1 <= 17'(seq_item.quad.src_left);
      end
      if (corner == svqe_pkg::CORNER_B || corner == svqe_pkg::CORNER_C) begin
        edge_v1 <= 17'(seq_item.quad.src_top);
      end else begin
        edge_v1 <= 17'(seq_item.quad.src_top) + 17'(seq_item.quad.src_height);
      end
      case (corner)
        svqe_pkg::CORNER_A: color1 <= color_a;
        svqe_pkg::CORNER_B: color1 <= color_b;
        svqe_pkg::CORNER_C: color1 <= color_c;
        svqe_pkg::CORNER_D: color1 <= color_d;
        default:            color1 <= color_a;
      endcase
      slot1 <= seq_item.slot;
      last1 <= (seq_item.slot == svqe_pkg::LAST_SLOT);
    end
  end

  // Delay the sideband to line up with the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      color2 <= color1;
      color3 <= color2;
      color4 <= color3;
      slot2  <= slot1;
      slot3  <= slot2;
      slot4  <= slot3;
      last2  <= last1;
      last3  <= last2;
      last4  <= last3;
    end
  end

  svqe_pos_lane u_lane_x (
    .clk    (clk),
    .adv    (adv),
    .row    (row_x),
    .px     (px1),
    .py     (py1),
    .origin (ox1),
    .result (res_x)
  );

  svqe_pos_lane u_lane_y (
    .clk    (clk),
    .adv    (adv),
    .row    (row_y),
    .px     (px1),
    .py     (py1),
    .origin (oy1),
    .result (res_y)
  );

  svqe_pos_lane u_lane_z (
    .clk    (clk),
    .adv    (adv),
    .row    (row_z),
    .px     (px1),
    .py     (py1),
    .origin ('0),
    .result (res_z)
  );

  svqe_tex_lane u_lane_u (
    .clk    (clk),
    .adv    (adv),
    .texels (edge_u1),
    .inv    (tex_inv_scale[23:0]),
    .result (res_u)
  );

  svqe_tex_lane u_lane_v (
    .clk    (clk),
    .adv    (adv),
    .texels (edge_v1),
    .inv    (tex_inv_scale[47:24]),
    .result (res_v)
  );

  // Drive the output channel from the last stage
  assign vertex.valid        = v4;
  assign vertex.pos_x        = res_x;
  assign vertex.pos_y        = res_y;
  assign vertex.pos_z        = res_z;
  assign vertex.tex_u        = res_u;
  assign vertex.tex_v        = res_v;
  assign vertex.vertex_color = color4;
  assign vertex.vertex_slot  = slot4;
  assign vertex.last_vertex  = last4;

  `SVQE_ASSERT_IMP(a_last_flag, clk, rst, vertex.valid, vertex.last_vertex == (vertex.vertex_slot == svqe_pkg::LAST_SLOT), "last flag does not match slot")
  `SVQE_ASSERT_NEXT(a_slot_follow, clk, rst, vertex.valid && vertex.ready && vertex.vertex_slot != svqe_pkg::LAST_SLOT, vertex.valid && vertex.vertex_slot == $past(vertex.vertex_slot) + 3'd1, "vertex slots of a quad not back to back")
  `SVQE_ASSERT_NEXT(a_out_hold, clk, rst, vertex.valid && !vertex.ready, vertex.valid && $stable(vertex.pos_x) && $stable(vertex.vertex_slot) && $stable(vertex.vertex_color), "waiting vertex changed during a stall")

endmodule

`default_nettype wire

FILE: hw/rtl/svqe_seq.sv
// ----------------------------------------------------------------------------
// svqe_seq
// Holds one quad and steps through its six vertex slots, one per advance.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sprite_quad_vertex_expander_defines.svh"

module svqe_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  svqe_quad_if.sink            quad,
  input  wire logic            adv,
  output svqe_pkg::seq_item_t  item
);

  logic                          busy;
  logic [svqe_pkg::SLOT_W-1:0]   slot;
  svqe_pkg::quad_t               held;

  // Take a new quad when empty or when the last slot leaves this cycle
  assign quad.ready = !busy || (adv && (slot == svqe_pkg::LAST_SLOT));

  // Load the quad, then advance the slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (quad.valid && quad.ready) begin
      busy <= 1'b1;
      slot <= '0;
    end else if (adv && busy) begin
      if (slot == svqe_pkg::LAST_SLOT) begin
        busy <= 1'b0;
      end else begin
        slot <= slot + 3'd1;
      end
    end
  end

  // Capture the quad payload
  always_ff @(posedge clk) begin
    if (quad.valid && quad.ready) begin
      held.dst_left   <= quad.dst_left;
      held.dst_top    <= quad.dst_top;
      held.dst_width  <= quad.dst_width;
      held.dst_height <= quad.dst_height;
      held.src_left   <= quad.src_left;
      held.src_top    <= quad.src_top;
      held.src_width  <= quad.src_width;
      held.src_height <= quad.src_height;
    end
  end

  assign item.valid = busy;
  assign item.slot  = slot;
  assign item.quad  = held;

  `SVQE_ASSERT_IMP(a_slot_range, clk, rst, busy, slot <= svqe_pkg::LAST_SLOT, "slot out of range")
  `SVQE_ASSERT_NEXT(a_load_first, clk, rst, quad.valid && quad.ready, busy && slot == 3'd0, "quad load did not restart at slot 0")
  `SVQE_ASSERT_NEXT(a_stall_hold, clk, rst, busy && !adv, busy && $stable(slot), "slot moved during a stall")

endmodule

`default_nettype wire

FILE: hw/rtl/svqe_pos_lane.sv
// ----------------------------------------------------------------------------
// svqe_pos_lane
// One affine row: products, rounded sum, saturation to signed Q16.8.
// Three register stages, all moved by the shared advance.
// ----------------------------------------------------------------------------
`default_nettype none

module svqe_pos_lane (
  input  wire logic                                  clk,
  input  wire logic                                  adv,
  input  wire logic [svqe_pkg::ROW_W-1:0]            row,
  input  wire logic signed [svqe_pkg::POS_W-1:0]     px,
  input  wire logic signed [svqe_pkg::POS_W-1:0]     py,
  input  wire logic signed [svqe_pkg::POS_W-1:0]     origin,
  output logic signed [svqe_pkg::POS_W-1:0]          result
);

  logic signed [svqe_pkg::COEF_W-1:0] cx;
  logic signed [svqe_pkg::COEF_W-1:0] cy;
  logic signed [svqe_pkg::POS_W-1:0]  off;

  logic signed [39:0] prod_x;
  logic signed [39:0] prod_y;
  logic signed [24:0] base;
  logic signed [41:0] acc;
  logic signed [29:0] whole;

  assign cx  = row[15:0];
  assign cy  = row[31:16];
  assign off = row[55:32];

  // Stage 2: coefficient products and offset plus origin
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x <= 40'(cx) * 40'(px);
      prod_y <= 40'(cy) * 40'(py);
      base   <= 25'(off) + 25'(origin);
    end
  end

  // Stage 3: sum at 20 fraction bits with half an output step added
  always_ff @(posedge clk) begin
    if (adv) begin
      acc <= 42'(prod_x) + 42'(prod_y) + (42'(base) <<< 12) + 42'sd2048;
    end
  end

  // Floor to 8 fraction bits
  assign whole = acc[41:12];

  // Stage 4: saturate to signed 24 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      if (whole[29:23] == {7{whole[29]}}) begin
        result <= whole[23:0];
      end else begin
        result <= whole[29] ? 24'sh800000 : 24'sh7FFFFF;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/svqe_tex_lane.sv
// ----------------------------------------------------------------------------
// svqe_tex_lane
// Texel edge times reciprocal texture size, rounded to Q8.16 and saturated.
// Three register stages, all moved by the shared advance.
// ----------------------------------------------------------------------------
`default_nettype none

module svqe_tex_lane (
  input  wire logic                           clk,
  input  wire logic                           adv,
  input  wire logic [svqe_pkg::EDGE_W-1:0]    texels,
  input  wire logic [svqe_pkg::INV_W-1:0]     inv,
  output logic [svqe_pkg::TEX_W-1:0]          result
);

  logic [40:0] prod;
  logic [41:0] sum;
  logic [34:0] coord;

  // Stage 2: product at 23 fraction bits
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= 41'(texels) * 41'(inv);
    end
  end

  // Stage 3: add half an output step
  always_ff @(posedge clk) begin
    if (adv) begin
      sum <= 42'(prod) + 42'd64;
    end
  end

  assign coord = sum[41:7];

  // Stage 4: clamp to 24 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      result <= (|coord[34:24]) ? 24'hFFFFFF : coord[23:0];
    end
  end

endmodule

`default_nettype wire

FILE: dv/sprite_quad_vertex_expander_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_quad_vertex_expander_tb
// Self-checking bench for the sprite quad expander. Quads go in over the quad
// channel and each accepted quad is expanded here into its six vertices:
// transformed and saturated positions, scaled texture edges and corner
// colours. The vertices that come out are compared field by field. Directed
// quads at reset and extreme register settings come first, then randomised
// phases, a back-to-back stream, and a long output hold-off.
// ----------------------------------------------------------------------------

module sprite_quad_vertex_expander_tb;
  import svqe_pkg::*;

  localparam realtime CLK_PERIOD     = 10.0;
  localparam int      VERTS_PER_QUAD = 6;
  localparam int      HOLD_CYCLES    = 150;
  localparam int      DRAIN_CYCLES   = 20;
  localparam int      TIMEOUT_CYCLES = 300000;
  localparam int      RANDOM_PHASES  = 4;
  localparam int      QUADS_PER_PHASE = 55;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [COLOR_W-1:0]      color;
    logic [SLOT_W-1:0]       slot;
    logic                    last;
  } vertex_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  svqe_quad_if   quad_ch ();
  svqe_vertex_if vtx_ch ();

  // Register shadows used for prediction
  logic [ROW_W-1:0]   row_x_r;
  logic [ROW_W-1:0]   row_y_r;
  logic [ROW_W-1:0]   row_z_r;
  logic [TEXS_W-1:0]  tex_inv_r;
  logic [COLOR_W-1:0] corner_rgba [4];
  logic [CFG_W-1:0]   next_cfg [8];

  vertex_t pending_vertices [$];

  int  mismatches       = 0;
  int  quads_sent       = 0;
  int  vertices_seen    = 0;
  int  settings_applied = 0;
  int  hold_left        = 0;
  bit  steady_flow      = 1'b0;
  bit  hold_request     = 1'b0;

  sprite_quad_vertex_expander u_top (
    .clk       (clk),
    .rst       (rst),
    .quad      (quad_ch),
    .vertex    (vtx_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Expansion arithmetic
  // ---------------------------------------------------------------------------

  // Affine row at 20 fraction bits, rounded to Q16.8 and saturated
  function automatic logic [POS_W-1:0] transform_row(input logic [ROW_W-1:0] row,
                                                     input longint px, input longint py,
                                                     input longint origin);
    longint cx, cy, off, acc;
    cx  = $signed(row[15:0]);
    cy  = $signed(row[31:16]);
    off = $signed(row[55:32]);
    acc = cx * px + cy * py + (off + origin) * 4096 + 2048;
    acc = acc >>> 12;
    if (acc > 64'sd8388607) acc = 64'sd8388607;
    else if (acc < -64'sd8388608) acc = -64'sd8388608;
    return acc[POS_W-1:0];
  endfunction

  // Texel edge times Q1.23 reciprocal, rounded to Q8.16 and saturated
  function automatic logic [TEX_W-1:0] scale_texel(input logic [EDGE_W-1:0] texels,
                                                   input logic [INV_W-1:0] inv);
    logic [47:0] p;
    p = (texels * inv + 48'd64) >> 7;
    return (p > 48'hFF_FFFF) ? 24'hFF_FFFF : p[TEX_W-1:0];
  endfunction

  // Queue the six vertices of an accepted quad, corner order 0,1,2,0,2,3
  task automatic expand_quad(input quad_t q);
    longint           w, h, px, py;
    logic [TEX_W-1:0] u0, u1, v0, v1;
    corner_t          c;
    vertex_t          v;
    u0 = scale_texel({1'b0, q.src_left}, tex_inv_r[23:0]);
    u1 = scale_texel({1'b0, q.src_left} + {1'b0, q.src_width}, tex_inv_r[23:0]);
    v0 = scale_texel({1'b0, q.src_top}, tex_inv_r[47:24]);
    v1 = scale_texel({1'b0, q.src_top} + {1'b0, q.src_height}, tex_inv_r[47:24]);
    w  = $signed(q.dst_width);
    h  = $signed(q.dst_height);
    for (int k = 0; k < VERTS_PER_QUAD; k++) begin
      case (k)
        0, 3:    c = CORNER_A;
        1:       c = CORNER_B;
        2, 4:    c = CORNER_C;
        default: c = CORNER_D;
      endcase
      px = (c == CORNER_C || c == CORNER_D) ? w : 64'sd0;
      py = (c == CORNER_B || c == CORNER_C) ? h : 64'sd0;
      v.pos_x = transform_row(row_x_r, px, py, $signed(q.dst_left));
      v.pos_y = transform_row(row_y_r, px, py, $signed(q.dst_top));
      v.pos_z = transform_row(row_z_r, px, py, 64'sd0);
      v.tex_u = (c == CORNER_C || c == CORNER_D) ? u1 : u0;
      v.tex_v = (c == CORNER_B || c == CORNER_C) ? v0 : v1;
      v.color = corner_rgba[c];
      v.slot  = k[SLOT_W-1:0];
      v.last  = (k[SLOT_W-1:0] == LAST_SLOT);
      pending_vertices.push_back(v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic quad_t make_quad(input logic [POS_W-1:0] l, t, w, h,
                                      input logic [SRC_W-1:0] sl, st, sw, sh);
    quad_t q;
    q.dst_left   = l;
    q.dst_top    = t;
    q.dst_width  = w;
    q.dst_height = h;
    q.src_left   = sl;
    q.src_top    = st;
    q.src_width  = sw;
    q.src_height = sh;
    return q;
  endfunction

  // Mostly screen-sized sprites; one in five is raw noise over every bit
  function automatic quad_t random_quad();
    quad_t q;
    if ($urandom_range(0, 4) == 0) begin
      q = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      q.dst_left   = 24'($urandom_range(0, 24'h7FFFF) - 32'h40000);
      q.dst_top    = 24'($urandom_range(0, 24'h7FFFF) - 32'h40000);
      q.dst_width  = 24'($urandom_range(0, 24'h1FFFF) - 32'h8000);
      q.dst_height = 24'($urandom_range(0, 24'h1FFFF) - 32'h8000);
      q.src_left   = 16'($urandom_range(0, 16'hFFF));
      q.src_top    = 16'($urandom_range(0, 16'hFFF));
      q.src_width  = 16'($urandom_range(0, 16'h3FF));
      q.src_height = 16'($urandom_range(0, 16'h3FF));
    end
    return q;
  endfunction

  function automatic logic [COEF_W-1:0] small_coef();
    return 16'($urandom_range(0, 16'h0800) - 32'h400);
  endfunction

  function automatic logic [POS_W-1:0] shift_q16();
    return 24'($urandom_range(0, 24'h3FFFF) - 32'h20000);
  endfunction

  // Offer one quad, hold it until taken, then maybe idle
  task automatic send_quad(input quad_t q);
    quad_ch.valid      <= 1'b1;
    quad_ch.dst_left   <= q.dst_left;
    quad_ch.dst_top    <= q.dst_top;
    quad_ch.dst_width  <= q.dst_width;
    quad_ch.dst_height <= q.dst_height;
    quad_ch.src_left   <= q.src_left;
    quad_ch.src_top    <= q.src_top;
    quad_ch.src_width  <= q.src_width;
    quad_ch.src_height <= q.src_height;
    @(posedge clk);
    while (!quad_ch.ready) @(posedge clk);
    expand_quad(q);
    quads_sent++;
    if (!steady_flow && $urandom_range(0, 99) < 20) begin
      quad_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every queued vertex has been seen
  task automatic wait_for_drain();
    quad_ch.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
  endtask

  // Write all eight registers from next_cfg, one per clock, and mirror them
  task automatic apply_settings();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= next_cfg[i];
      @(posedge clk);
      case (cfg_reg_t'(i))
        CFG_ROW_X:   row_x_r        = next_cfg[i][ROW_W-1:0];
        CFG_ROW_Y:   row_y_r        = next_cfg[i][ROW_W-1:0];
        CFG_ROW_Z:   row_z_r        = next_cfg[i][ROW_W-1:0];
        CFG_TEX_INV: tex_inv_r      = next_cfg[i][TEXS_W-1:0];
        CFG_COLOR_A: corner_rgba[0] = next_cfg[i][COLOR_W-1:0];
        CFG_COLOR_B: corner_rgba[1] = next_cfg[i][COLOR_W-1:0];
        CFG_COLOR_C: corner_rgba[2] = next_cfg[i][COLOR_W-1:0];
        CFG_COLOR_D: corner_rgba[3] = next_cfg[i][COLOR_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Either raw random data or a near-identity transform with sane reciprocals
  task automatic randomise_settings(input bit wild);
    if (wild) begin
      for (int i = 0; i < 8; i++) next_cfg[i] = 56'({$urandom, $urandom});
    end else begin
      next_cfg[CFG_ROW_X]   = {shift_q16(), small_coef(), 16'($urandom_range(0, 16'h3000))};
      next_cfg[CFG_ROW_Y]   = {shift_q16(), 16'($urandom_range(0, 16'h3000)), small_coef()};
      next_cfg[CFG_ROW_Z]   = {shift_q16(), small_coef(), small_coef()};
      next_cfg[CFG_TEX_INV] = {8'($urandom), 24'($urandom_range(1, 24'h80_0000)),
                               24'($urandom_range(1, 24'h80_0000))};
      for (int i = CFG_COLOR_A; i <= CFG_COLOR_D; i++)
        next_cfg[i] = 56'({$urandom, $urandom});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Vertex channel: ready with random stalls, plus an on-demand long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      vtx_ch.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left = HOLD_CYCLES - 1;
      vtx_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      vtx_ch.ready <= 1'b0;
    end else begin
      vtx_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 20);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each vertex transaction with the oldest queued vertex
  always @(posedge clk) begin : vertex_checker
    vertex_t want;
    if (!rst && vtx_ch.valid && vtx_ch.ready) begin
      if (pending_vertices.size() == 0) begin
        $error("vertex transaction with no quad outstanding (slot %0d)", vtx_ch.vertex_slot);
        mismatches++;
      end else begin
        want = pending_vertices.pop_front();
        check_field("pos_x", want.pos_x, vtx_ch.pos_x);
        check_field("pos_y", want.pos_y, vtx_ch.pos_y);
        check_field("pos_z", want.pos_z, vtx_ch.pos_z);
        check_field("tex_u", want.tex_u, vtx_ch.tex_u);
        check_field("tex_v", want.tex_v, vtx_ch.tex_v);
        check_field("vertex_color", want.color, vtx_ch.vertex_color);
        check_field("vertex_slot", want.slot, vtx_ch.vertex_slot);
        check_field("last_vertex", want.last, vtx_ch.last_vertex);
        vertices_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Identity transform after reset: zero, extreme, mirrored and rounding quads
  task automatic test_reset_config();
    send_quad(make_quad(24'h0, 24'h0, 24'h0, 24'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_quad(make_quad(24'h0, 24'h0, 24'h1000, 24'h1000, 16'h0, 16'h0, 16'd32, 16'd32));
    send_quad(make_quad(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_quad(make_quad(24'h800000, 24'h800000, 24'h800000, 24'h800000,
                        16'h0, 16'h0, 16'h0, 16'h0));
    send_quad(make_quad(24'h1000, 24'h1000, 24'hFFF800, 24'hFFF800,
                        16'd10, 16'd20, 16'd5, 16'd6));
    send_quad(make_quad(24'h100, 24'h200, 24'h0, 24'h2000, 16'd7, 16'd9, 16'd0, 16'd64));
    send_quad(make_quad(24'hFFFFFF, 24'hFFFFFF, 24'h1, 24'h1, 16'h8000, 16'h8000,
                        16'h8000, 16'h8000));
    wait_for_drain();
  endtask

  // Largest, most negative, all-ones and all-zero register contents
  task automatic test_config_extremes();
    next_cfg[CFG_ROW_X]   = {24'h7FFFFF, 16'h7FFF, 16'h7FFF};
    next_cfg[CFG_ROW_Y]   = {24'h800000, 16'h8000, 16'h8000};
    next_cfg[CFG_ROW_Z]   = {24'h7FFFFF, 16'h8000, 16'h7FFF};
    next_cfg[CFG_TEX_INV] = {8'h00, 48'hFFFFFF_FFFFFF};
    next_cfg[CFG_COLOR_A] = 56'h0;
    next_cfg[CFG_COLOR_B] = 56'hFF_FFFF_FFFF_FFFF;
    next_cfg[CFG_COLOR_C] = 56'hA5A5A5A5;
    next_cfg[CFG_COLOR_D] = 56'h5A5A5A5A;
    apply_settings();
    send_quad(make_quad(24'h0, 24'h0, 24'h0, 24'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_quad(make_quad(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_quad(make_quad(24'h800000, 24'h800000, 24'h800000, 24'h800000,
                        16'h1, 16'h1, 16'h1, 16'h1));
    send_quad(make_quad(24'h0, 24'h0, 24'hFFFFFF, 24'h1, 16'd3, 16'd4, 16'd1, 16'd1));
    wait_for_drain();

    for (int i = 0; i < 8; i++) next_cfg[i] = 56'hFF_FFFF_FFFF_FFFF;
    apply_settings();
    send_quad(make_quad(24'h123456, 24'hEDCBA9, 24'h000800, 24'hFFF000,
                        16'h1234, 16'hFEDC, 16'h0100, 16'h0200));
    send_quad(make_quad(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
                        16'hFFFF, 16'h0, 16'h0, 16'hFFFF));
    wait_for_drain();

    for (int i = 0; i < 8; i++) next_cfg[i] = 56'h0;
    apply_settings();
    send_quad(make_quad(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_quad(make_quad(24'h0ABCDE, 24'hF54321, 24'h001000, 24'h001000,
                        16'd100, 16'd200, 16'd50, 16'd60));
    wait_for_drain();
  endtask

  // Alternate near-identity and raw random register settings
  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      randomise_settings(p[0]);
      apply_settings();
      repeat (QUADS_PER_PHASE) send_quad(random_quad());
      wait_for_drain();
    end
  endtask

  // Back-to-back quads with both sides always ready
  task automatic test_steady_stream();
    randomise_settings(1'b0);
    apply_settings();
    steady_flow = 1'b1;
    repeat (25) send_quad(random_quad());
    wait_for_drain();
    steady_flow = 1'b0;
  endtask

  // Hold the vertex side off while quads keep coming, so the input backs up
  task automatic test_output_hold_off();
    steady_flow = 1'b1;
    hold_request <= 1'b1;
    repeat (16) send_quad(random_quad());
    wait_for_drain();
    steady_flow = 1'b0;
  endtask

  task automatic finish_run();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run summary: %0d quads, %0d vertices checked, %0d register settings",
             quads_sent, vertices_seen, settings_applied);
    $display("Exercised reset, extreme and random transforms, saturation, mirrored quads,");
    $display("back-to-back flow and a %0d-cycle vertex hold-off", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = CFG_ROW_X;
    cfg_data           = '0;
    quad_ch.valid      = 1'b0;
    quad_ch.dst_left   = '0;
    quad_ch.dst_top    = '0;
    quad_ch.dst_width  = '0;
    quad_ch.dst_height = '0;
    quad_ch.src_left   = '0;
    quad_ch.src_top    = '0;
    quad_ch.src_width  = '0;
    quad_ch.src_height = '0;
    vtx_ch.ready       = 1'b0;
    row_x_r            = ROW_X_RST;
    row_y_r            = ROW_Y_RST;
    row_z_r            = ROW_Z_RST;
    tex_inv_r          = TEX_INV_RST;
    for (int i = 0; i < 4; i++) corner_rgba[i] = COLOR_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_config_extremes();
    test_random_traffic();
    test_steady_stream();
    test_output_hold_off();
    finish_run();
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d vertices outstanding", pending_vertices.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/svqe_pkg.sv
hw/rtl/svqe_quad_if.sv
hw/rtl/svqe_vertex_if.sv
hw/rtl/svqe_seq.sv
hw/rtl/svqe_pos_lane.sv
hw/rtl/svqe_tex_lane.sv
hw/rtl/sprite_quad_vertex_expander.sv
dv/sprite_quad_vertex_expander_tb.sv
